// ----- hw/rtl/bbg_pkg.sv -----
// Shared constants, cell state codes, command codes and the cell update rule
// for the three-state automaton engine. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bbg_pkg;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 128;

    localparam int CELL_W  = 2;
    localparam int LB_ROWS = 3;
    localparam int SLOT_W  = 2;

    localparam int GRID_WIDTH_W  = 9;
    localparam int GRID_HEIGHT_W = 8;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [GRID_WIDTH_W-1:0]  RST_GRID_WIDTH  = 9'd200;
    localparam logic [GRID_HEIGHT_W-1:0] RST_GRID_HEIGHT = 8'd120;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_ADVANCE = 2'd1;
    localparam logic [1:0] CMD_READ    = 2'd2;

    localparam logic [CELL_W-1:0] CELL_READY      = 2'd0;
    localparam logic [CELL_W-1:0] CELL_REFRACTORY = 2'd1;
    localparam logic [CELL_W-1:0] CELL_FIRING     = 2'd2;

    localparam logic [3:0] FIRE_TRIGGER = 4'd2;

    function automatic logic [CELL_W-1:0] cell_next(input logic [CELL_W-1:0] centre,
                                                    input logic [3:0] firing);
        logic [CELL_W-1:0] res;
        case (centre)
            CELL_READY: begin
                res = (firing == FIRE_TRIGGER) ? CELL_FIRING : CELL_READY;
            end
            CELL_FIRING: begin
                res = CELL_REFRACTORY;
            end
            default: begin
                res = CELL_READY;
            end
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/bbg_grid_mem.sv -----
// Cell grid memory: one write port, one registered read port.
// Depends on bbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbg_grid_mem #(
    parameter int MAX_COLS = bbg_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bbg_pkg::DEF_MAX_ROWS,
    localparam int COL_W = $clog2(MAX_COLS),
    localparam int ROW_W = $clog2(MAX_ROWS)
) (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [ROW_W-1:0]          wr_row,
    input  wire logic [COL_W-1:0]          wr_col,
    input  wire logic [bbg_pkg::CELL_W-1:0] wr_data,
    input  wire logic                      rd_en,
    input  wire logic [ROW_W-1:0]          rd_row,
    input  wire logic [COL_W-1:0]          rd_col,
    output logic      [bbg_pkg::CELL_W-1:0] rd_data
);
    import bbg_pkg::*;

    logic [CELL_W-1:0] mem [MAX_ROWS][MAX_COLS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_col] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_row][rd_col];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bbg_line_buf.sv -----
// Three saved old rows used while a generation sweeps the grid.
// All rows are read at one column per cycle; one row is written. Depends on bbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbg_line_buf #(
    parameter int MAX_COLS = bbg_pkg::DEF_MAX_COLS,
    localparam int COL_W = $clog2(MAX_COLS)
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [bbg_pkg::SLOT_W-1:0]   wr_slot,
    input  wire logic [COL_W-1:0]             wr_col,
    input  wire logic [bbg_pkg::CELL_W-1:0]   wr_data,
    input  wire logic [COL_W-1:0]             rd_col,
    output logic [bbg_pkg::LB_ROWS-1:0][bbg_pkg::CELL_W-1:0] rd_data
);
    import bbg_pkg::*;

    for (genvar k = 0; k < LB_ROWS; k++) begin : g_row
        logic [CELL_W-1:0] mem [MAX_COLS];

        always_ff @(posedge aclk) begin
            if (wr_en && (wr_slot == SLOT_W'(k))) begin
                mem[wr_col] <= wr_data;
            end
            rd_data[k] <= mem[rd_col];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bbg_window.sv -----
// Three by three neighborhood window and cell update rule, fed one column
// per cycle during a generation. Depends on bbg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbg_window (
    input  wire logic                       aclk,
    input  wire logic                       shift_en,
    input  wire logic                       clear,
    input  wire logic                       top_fire,
    input  wire logic [bbg_pkg::CELL_W-1:0] mid_state,
    input  wire logic                       bot_fire,
    output logic      [bbg_pkg::CELL_W-1:0] next_state
);
    import bbg_pkg::*;

    logic [2:0]             top_reg;
    logic [2:0]             bot_reg;
    logic [2:0][CELL_W-1:0] mid_reg;
    logic [3:0]             firing;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            top_reg[2] <= top_fire;
            bot_reg[2] <= bot_fire;
            mid_reg[2] <= mid_state;
            if (clear) begin
                top_reg[1:0] <= '0;
                bot_reg[1:0] <= '0;
                mid_reg[1]   <= CELL_READY;
                mid_reg[0]   <= CELL_READY;
            end else begin
                top_reg[1:0] <= top_reg[2:1];
                bot_reg[1:0] <= bot_reg[2:1];
                mid_reg[1]   <= mid_reg[2];
                mid_reg[0]   <= mid_reg[1];
            end
        end
    end

    always_comb begin
        firing = 4'($countones(top_reg)) + 4'($countones(bot_reg))
               + 4'(mid_reg[0] == CELL_FIRING) + 4'(mid_reg[2] == CELL_FIRING);
        next_state = cell_next(mid_reg[1], firing);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/three_state_automaton_generation.sv -----
// Top level of the three-state automaton engine: command sequencer, config
// registers, result register. Depends on bbg_pkg, bbg_grid_mem, bbg_line_buf, bbg_window.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_tvalid / s_tready  s_tuser cmd; s_tdata col, row, new_state
//   m_        out        m_tvalid / m_tready  m_tuser bad_coord; m_tdata read_state
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A write, a bad access or an unused command passes through EXEC and FINISH; a read also
// through RD_DATA. An advance sweeps the used h by w grid one cell per cycle through
// the single grid memory read port, plus a column and a row of drain. After reset a
// clearing pass writes every one of
// MAX_ROWS * MAX_COLS cells (one per cycle) with s_tready low.
// The result register holds under m_tready low; one more transaction is taken
// meanwhile and waits at its end until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module three_state_automaton_generation #(
    parameter int MAX_COLS = bbg_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = bbg_pkg::DEF_MAX_ROWS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // col[7:0], row[14:8], new_state[16:15], zero fill
    input  wire logic [1:0]  s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // read_state[1:0], zero fill
    output logic [0:0]       m_tuser,   // bad_coord[0]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [bbg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [bbg_pkg::GRID_WIDTH_W-1:0]  cfg_data
);
    import bbg_pkg::*;

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int QC_W  = $clog2(MAX_COLS + 1);
    localparam int PC_W  = $clog2(MAX_ROWS + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RD_DATA,
        ST_GEN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    logic [GRID_WIDTH_W-1:0]  grid_width_reg;
    logic [GRID_HEIGHT_W-1:0] grid_height_reg;
    logic [QC_W-1:0]          used_cols;
    logic [PC_W-1:0]          used_rows;

    logic [1:0]        cmd_reg;
    logic [7:0]        cmd_col_reg;
    logic [6:0]        cmd_row_reg;
    logic [CELL_W-1:0] cmd_ns_reg;
    logic              bad;

    logic [ROW_W-1:0] clr_row_reg;
    logic [COL_W-1:0] clr_col_reg;

    logic [PC_W-1:0]   p_reg;
    logic [QC_W-1:0]   q_reg;
    logic [SLOT_W-1:0] s_reg;
    logic [SLOT_W-1:0] s_prev;
    logic [SLOT_W-1:0] s_pp;
    logic [PC_W-1:0]   p_m1;
    logic [QC_W-1:0]   q_m1;
    logic              issue;
    logic              in_grid;
    logic              last_pos;
    logic              drain_reg;

    logic              p1_v_reg;
    logic              p1_in_grid_reg;
    logic              p1_top_ok_reg;
    logic              p1_mid_ok_reg;
    logic              p1_q0_reg;
    logic              p1_out_reg;
    logic [ROW_W-1:0]  p1_row_reg;
    logic [COL_W-1:0]  p1_col_reg;
    logic [COL_W-1:0]  p1_q_reg;
    logic [SLOT_W-1:0] p1_slot_reg;
    logic [SLOT_W-1:0] p1_prev_reg;
    logic [SLOT_W-1:0] p1_pp_reg;

    logic              p2_v_reg;
    logic              p2_out_reg;
    logic [ROW_W-1:0]  p2_row_reg;
    logic [COL_W-1:0]  p2_col_reg;

    logic [CELL_W-1:0] res_state_reg;
    logic              res_bad_reg;
    logic              m_tvalid_reg;
    logic [CELL_W-1:0] out_state_reg;
    logic              out_bad_reg;

    logic              gw_en;
    logic [ROW_W-1:0]  gw_row;
    logic [COL_W-1:0]  gw_col;
    logic [CELL_W-1:0] gw_data;
    logic              gr_en;
    logic [ROW_W-1:0]  gr_row;
    logic [COL_W-1:0]  gr_col;
    logic [CELL_W-1:0] gr_data;

    logic [LB_ROWS-1:0][CELL_W-1:0] lb_rd;
    logic [CELL_W-1:0]              win_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'b0, out_state_reg};
    assign m_tuser   = out_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_IDX_WIDTH: begin
                    grid_width_reg <= cfg_data;
                end
                CFG_IDX_HEIGHT: begin
                    grid_height_reg <= cfg_data[GRID_HEIGHT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        used_cols = (int'(grid_width_reg) > MAX_COLS) ? QC_W'(MAX_COLS)
                                                      : QC_W'(grid_width_reg);
        used_rows = (int'(grid_height_reg) > MAX_ROWS) ? PC_W'(MAX_ROWS)
                                                       : PC_W'(grid_height_reg);
        bad = (32'(cmd_col_reg) >= 32'(used_cols)) || (32'(cmd_row_reg) >= 32'(used_rows));

        issue    = (state_reg == ST_GEN);
        in_grid  = (p_reg < used_rows) && (q_reg < used_cols);
        last_pos = (p_reg == used_rows) && (q_reg == used_cols);
        p_m1     = p_reg - PC_W'(1);
        q_m1     = q_reg - QC_W'(1);
        s_prev   = (s_reg == '0) ? SLOT_W'(LB_ROWS - 1) : s_reg - SLOT_W'(1);
        s_pp     = (s_reg == SLOT_W'(LB_ROWS - 1)) ? '0 : s_reg + SLOT_W'(1);
    end

    always_comb begin
        gw_en   = 1'b0;
        gw_row  = p2_row_reg;
        gw_col  = p2_col_reg;
        gw_data = win_next;
        if (state_reg == ST_CLEAR) begin
            gw_en   = 1'b1;
            gw_row  = clr_row_reg;
            gw_col  = clr_col_reg;
            gw_data = CELL_READY;
        end else if (state_reg == ST_EXEC && cmd_reg == CMD_WRITE && !bad) begin
            gw_en   = 1'b1;
            gw_row  = ROW_W'(cmd_row_reg);
            gw_col  = COL_W'(cmd_col_reg);
            gw_data = (cmd_ns_reg > CELL_FIRING) ? CELL_READY : cmd_ns_reg;
        end else if (p2_v_reg && p2_out_reg) begin
            gw_en = 1'b1;
        end

        if (issue) begin
            gr_en  = in_grid;
            gr_row = p_reg[ROW_W-1:0];
            gr_col = q_reg[COL_W-1:0];
        end else begin
            gr_en  = (state_reg == ST_EXEC) && (cmd_reg == CMD_READ) && !bad;
            gr_row = ROW_W'(cmd_row_reg);
            gr_col = COL_W'(cmd_col_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_row_reg  <= '0;
            clr_col_reg  <= '0;
            p_reg        <= '0;
            q_reg        <= '0;
            s_reg        <= '0;
            drain_reg    <= 1'b0;
            p1_v_reg     <= 1'b0;
            p2_v_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            p1_v_reg <= issue;
            p2_v_reg <= p1_v_reg;
            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    if (clr_col_reg == COL_W'(MAX_COLS - 1)) begin
                        clr_col_reg <= '0;
                        clr_row_reg <= clr_row_reg + ROW_W'(1);
                        if (clr_row_reg == ROW_W'(MAX_ROWS - 1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        clr_col_reg <= clr_col_reg + COL_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (cmd_reg == CMD_ADVANCE) begin
                        p_reg <= '0;
                        q_reg <= '0;
                        s_reg <= '0;
                        if (used_cols == '0 || used_rows == '0) begin
                            state_reg <= ST_FINISH;
                        end else begin
                            state_reg <= ST_GEN;
                        end
                    end else if (cmd_reg == CMD_READ && !bad) begin
                        state_reg <= ST_RD_DATA;
                    end else begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_RD_DATA: begin
                    state_reg <= ST_FINISH;
                end
                ST_GEN: begin
                    if (last_pos) begin
                        drain_reg <= 1'b0;
                        state_reg <= ST_DRAIN;
                    end else if (q_reg == used_cols) begin
                        q_reg <= '0;
                        p_reg <= p_reg + PC_W'(1);
                        s_reg <= s_pp;
                    end else begin
                        q_reg <= q_reg + QC_W'(1);
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= 1'b1;
                    if (drain_reg) begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg     <= s_tuser;
            cmd_col_reg <= s_tdata[7:0];
            cmd_row_reg <= s_tdata[14:8];
            cmd_ns_reg  <= s_tdata[16:15];
        end
        if (state_reg == ST_EXEC) begin
            res_state_reg <= CELL_READY;
            res_bad_reg   <= (cmd_reg == CMD_WRITE || cmd_reg == CMD_READ) && bad;
        end
        if (state_reg == ST_RD_DATA) begin
            res_state_reg <= gr_data;
        end
        if (state_reg == ST_FINISH && (!m_tvalid_reg || m_tready)) begin
            out_state_reg <= res_state_reg;
            out_bad_reg   <= res_bad_reg;
        end

        p1_in_grid_reg <= in_grid;
        p1_top_ok_reg  <= (p_reg >= PC_W'(2)) && (q_reg < used_cols);
        p1_mid_ok_reg  <= (p_reg != '0) && (q_reg < used_cols);
        p1_q0_reg      <= (q_reg == '0);
        p1_out_reg     <= (p_reg != '0) && (q_reg != '0);
        p1_row_reg     <= p_m1[ROW_W-1:0];
        p1_col_reg     <= q_m1[COL_W-1:0];
        p1_q_reg       <= q_reg[COL_W-1:0];
        p1_slot_reg    <= s_reg;
        p1_prev_reg    <= s_prev;
        p1_pp_reg      <= s_pp;

        p2_out_reg <= p1_out_reg;
        p2_row_reg <= p1_row_reg;
        p2_col_reg <= p1_col_reg;
    end

    bbg_grid_mem #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_grid_mem (
        .aclk    (aclk),
        .wr_en   (gw_en),
        .wr_row  (gw_row),
        .wr_col  (gw_col),
        .wr_data (gw_data),
        .rd_en   (gr_en),
        .rd_row  (gr_row),
        .rd_col  (gr_col),
        .rd_data (gr_data)
    );

    bbg_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .aclk    (aclk),
        .wr_en   (p1_v_reg && p1_in_grid_reg),
        .wr_slot (p1_slot_reg),
        .wr_col  (p1_q_reg),
        .wr_data (gr_data),
        .rd_col  (q_reg[COL_W-1:0]),
        .rd_data (lb_rd)
    );

    bbg_window u_window (
        .aclk       (aclk),
        .shift_en   (p1_v_reg),
        .clear      (p1_q0_reg),
        .top_fire   (p1_top_ok_reg && (lb_rd[p1_pp_reg] == CELL_FIRING)),
        .mid_state  (p1_mid_ok_reg ? lb_rd[p1_prev_reg] : CELL_READY),
        .bot_fire   (p1_in_grid_reg && (gr_data == CELL_FIRING)),
        .next_state (win_next)
    );

    a_gen_row_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue && gw_en && gr_en) |-> (gw_row != gr_row))
        else $error("generation writes the row it is reading");

    a_gen_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (p2_v_reg && p2_out_reg) |-> (32'(p2_col_reg) < 32'(used_cols)))
        else $error("generation writes outside the used columns");

    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && !m_tvalid_reg) |=> m_tvalid_reg)
        else $error("finished result not loaded into a free output register");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking bench for three_state_automaton_generation: queued cell commands,
// random gaps and stalls on both streams, and a grid predictor checked against every result.
// Depends on bbg_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
    import bbg_pkg::*;

    localparam int GRID_COLS = DEF_MAX_COLS;
    localparam int GRID_ROWS = DEF_MAX_ROWS;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CELL_W-1:0] CELL_CODE_3 = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] col;
        logic [6:0] row;
        logic [1:0] state;
    } cell_cmd_t;

    typedef struct packed {
        logic [1:0] read_state;
        logic       bad_coord;
    } cell_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [GRID_WIDTH_W-1:0] cfg_data = '0;

    logic [CELL_W-1:0] cell_img [GRID_ROWS][GRID_COLS];
    logic [CELL_W-1:0] gen_prior [GRID_ROWS][GRID_COLS];
    logic [GRID_WIDTH_W-1:0]  cols_reg = RST_GRID_WIDTH;
    logic [GRID_HEIGHT_W-1:0] rows_reg = RST_GRID_HEIGHT;

    cell_cmd_t    cmd_q[$];
    cell_result_t pending_results[$];
    cell_cmd_t    offered;
    int send_gap = 0;
    int recv_left = 0;
    int items_sent = 0;
    int results_seen = 0;
    int mismatches = 0;
    int cycle_count = 0;
    logic no_idle = 1'b0;
    logic hold_go = 1'b0;
    logic rx_hold = 1'b0;

    three_state_automaton_generation dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic int used_cols();
        return (int'(cols_reg) > GRID_COLS) ? GRID_COLS : int'(cols_reg);
    endfunction

    function automatic int used_rows();
        return (int'(rows_reg) > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
    endfunction

    function automatic void step_generation();
        int uc, ur, r, c, dr, dc, rr, cc, n;
        uc = used_cols();
        ur = used_rows();
        for (r = 0; r < ur; r++)
            for (c = 0; c < uc; c++)
                gen_prior[r][c] = cell_img[r][c];
        for (r = 0; r < ur; r++) begin
            for (c = 0; c < uc; c++) begin
                if (gen_prior[r][c] == CELL_READY) begin
                    n = 0;
                    for (dr = -1; dr <= 1; dr++) begin
                        for (dc = -1; dc <= 1; dc++) begin
                            rr = r + dr;
                            cc = c + dc;
                            if ((dr != 0 || dc != 0) && rr >= 0 && rr < ur && cc >= 0 && cc < uc
                                && gen_prior[rr][cc] == CELL_FIRING)
                                n++;
                        end
                    end
                    cell_img[r][c] = (n == 2) ? CELL_FIRING : CELL_READY;
                end else if (gen_prior[r][c] == CELL_FIRING) begin
                    cell_img[r][c] = CELL_REFRACTORY;
                end else begin
                    cell_img[r][c] = CELL_READY;
                end
            end
        end
    endfunction

    function automatic void predict_command(input cell_cmd_t item);
        cell_result_t res;
        res = '0;
        if (item.op == CMD_WRITE || item.op == CMD_READ) begin
            if (int'(item.col) >= used_cols() || int'(item.row) >= used_rows())
                res.bad_coord = 1'b1;
            else if (item.op == CMD_WRITE)
                cell_img[item.row][item.col] = (item.state == CELL_CODE_3) ? CELL_READY
                                                                             : item.state;
            else
                res.read_state = cell_img[item.row][item.col];
        end else if (item.op == CMD_ADVANCE) begin
            step_generation();
        end
        pending_results.push_back(res);
    endfunction

    task automatic flag_mismatch(input string what, input int want, input int got);
        $display("MISMATCH %s: expected %0d, got %0d at cycle %0d", what, want, got,
                 cycle_count);
        mismatches++;
    endtask

    task automatic queue_cmd(input logic [1:0] op, input int col, input int row,
                             input logic [1:0] state);
        cell_cmd_t item;
        item.op = op;
        item.col = col[7:0];
        item.row = row[6:0];
        item.state = state;
        cmd_q.push_back(item);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [GRID_WIDTH_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_IDX_WIDTH)
            cols_reg = val;
        else
            rows_reg = val[GRID_HEIGHT_W-1:0];
    endtask

    task automatic wait_drained();
        while (results_seen != items_sent) @(posedge aclk);
    endtask

    // drive the command stream
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready)
                predict_command(offered);
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (cmd_q.size() != 0) begin
                    offered = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= offered.op;
                    s_tdata <= {7'd0, offered.state, offered.row, offered.col};
                    send_gap <= no_idle ? 0 : int'($urandom_range(0, 3));
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // accept and check each result transaction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch("result with nothing pending", -1, int'(m_tuser[0]));
                end else begin
                    if (m_tdata[1:0] != pending_results[0].read_state)
                        flag_mismatch("read_state", int'(pending_results[0].read_state),
                                      int'(m_tdata[1:0]));
                    if (m_tuser[0] != pending_results[0].bad_coord)
                        flag_mismatch("bad_coord", int'(pending_results[0].bad_coord),
                                      int'(m_tuser[0]));
                    void'(pending_results.pop_front());
                    results_seen++;
                end
                recv_left = no_idle ? 0 : int'($urandom_range(0, 3));
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (recv_left > 0) begin
                recv_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // hold off the result stream for a long stretch
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int p, k, pick, uc, ur, col, row;
        logic [1:0] op, st;
        int run_cols [8];
        int run_rows [8];

        run_cols = '{1, 3, 12, 3, 256, 16, 7, 2};
        run_rows = '{1, 3, 8, 128, 2, 10, 5, 6};

        for (int r = 0; r < GRID_ROWS; r++)
            for (int c = 0; c < GRID_COLS; c++)
                cell_img[r][c] = CELL_READY;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // default 200 x 120 grid
        queue_cmd(CMD_WRITE, 0, 0, CELL_FIRING);
        queue_cmd(CMD_WRITE, 1, 0, CELL_FIRING);
        queue_cmd(CMD_WRITE, 199, 119, CELL_REFRACTORY);
        queue_cmd(CMD_WRITE, 198, 119, CELL_CODE_3);
        queue_cmd(CMD_WRITE, 200, 0, CELL_FIRING);
        queue_cmd(CMD_WRITE, 0, 120, CELL_FIRING);
        queue_cmd(CMD_READ, 0, 0, CELL_READY);
        queue_cmd(CMD_READ, 199, 119, CELL_READY);
        queue_cmd(CMD_READ, 198, 119, CELL_READY);
        queue_cmd(CMD_READ, 255, 127, CELL_CODE_3);
        queue_cmd(CMD_UNUSED, 255, 127, CELL_CODE_3);
        queue_cmd(CMD_ADVANCE, 0, 0, CELL_READY);
        queue_cmd(CMD_READ, 0, 1, CELL_READY);
        queue_cmd(CMD_READ, 1, 1, CELL_READY);
        queue_cmd(CMD_READ, 0, 0, CELL_READY);
        queue_cmd(CMD_READ, 199, 119, CELL_READY);
        queue_cmd(CMD_WRITE, 199, 118, CELL_FIRING);
        queue_cmd(CMD_WRITE, 198, 118, CELL_FIRING);
        queue_cmd(CMD_ADVANCE, 0, 0, CELL_READY);
        queue_cmd(CMD_READ, 199, 117, CELL_READY);
        queue_cmd(CMD_READ, 198, 119, CELL_READY);
        queue_cmd(CMD_READ, 199, 118, CELL_READY);
        wait_drained();

        // full store, then oversized registers
        write_reg(CFG_IDX_WIDTH, 9'd256);
        write_reg(CFG_IDX_HEIGHT, 9'd128);
        queue_cmd(CMD_WRITE, 255, 127, CELL_FIRING);
        queue_cmd(CMD_WRITE, 254, 127, CELL_FIRING);
        queue_cmd(CMD_READ, 255, 127, CELL_READY);
        queue_cmd(CMD_ADVANCE, 0, 0, CELL_READY);
        queue_cmd(CMD_READ, 253, 126, CELL_READY);
        queue_cmd(CMD_READ, 255, 127, CELL_READY);
        wait_drained();
        write_reg(CFG_IDX_WIDTH, 9'd511);
        write_reg(CFG_IDX_HEIGHT, 9'd255);
        queue_cmd(CMD_WRITE, 128, 64, CELL_FIRING);
        queue_cmd(CMD_WRITE, 127, 63, CELL_FIRING);
        queue_cmd(CMD_ADVANCE, 0, 0, CELL_READY);
        queue_cmd(CMD_READ, 255, 126, CELL_READY);
        queue_cmd(CMD_READ, 128, 63, CELL_READY);
        queue_cmd(CMD_READ, 255, 127, CELL_READY);
        wait_drained();

        // empty grid in either direction
        write_reg(CFG_IDX_WIDTH, 9'd0);
        write_reg(CFG_IDX_HEIGHT, 9'd128);
        queue_cmd(CMD_WRITE, 0, 0, CELL_FIRING);
        queue_cmd(CMD_ADVANCE, 0, 0, CELL_READY);
        queue_cmd(CMD_READ, 0, 0, CELL_READY);
        wait_drained();
        write_reg(CFG_IDX_WIDTH, 9'd5);
        write_reg(CFG_IDX_HEIGHT, 9'd0);
        queue_cmd(CMD_READ, 1, 0, CELL_READY);
        queue_cmd(CMD_ADVANCE, 0, 0, CELL_READY);
        wait_drained();

        // random runs on small grids
        for (p = 0; p < 8; p++) begin
            write_reg(CFG_IDX_WIDTH, run_cols[p][8:0]);
            write_reg(CFG_IDX_HEIGHT, run_rows[p][8:0]);
            uc = used_cols();
            ur = used_rows();
            no_idle = (p == 4);
            if (p == 2)
                hold_go = 1'b1;
            for (k = 0; k < 8; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    op = CMD_UNUSED;
                else if (pick < 22)
                    op = CMD_ADVANCE;
                else if (pick < 62)
                    op = CMD_WRITE;
                else
                    op = CMD_READ;
                if ($urandom_range(0, 9) == 0) begin
                    col = $urandom_range(0, 255);
                    row = $urandom_range(0, 127);
                end else begin
                    col = $urandom_range(0, uc - 1);
                    row = $urandom_range(0, ur - 1);
                end
                st = $urandom_range(0, 1) ? CELL_FIRING : 2'($urandom_range(0, 3));
                queue_cmd(op, col, row, st);
            end
            wait_drained();
        end
        no_idle = 1'b0;

        repeat (40) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/bbg_pkg.sv
hw/rtl/bbg_grid_mem.sv
hw/rtl/bbg_line_buf.sv
hw/rtl/bbg_window.sv
hw/rtl/three_state_automaton_generation.sv
test/tb_top.sv
